### hdl/buzzer_tone_sequencer_top_macros.svh
// Assertion macros shared by the buzzer tone sequencer RTL.
`ifndef BUZZER_TONE_SEQUENCER_TOP_MACROS_SVH
`define BUZZER_TONE_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BTS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BTS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bts_pkg.sv
// Types, codes and reset constants of the buzzer tone sequencer.
`timescale 1ns / 1ps
package bts_pkg;

  localparam int unsigned FreqW  = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CountW-1:0] BeepsEndless = 8'd255;

  localparam logic [FreqW-1:0]  BeepToneRst  = 16'd3200;
  localparam logic [FreqW-1:0]  SweepLowRst  = 16'd300;
  localparam logic [FreqW-1:0]  SweepHighRst = 16'd6200;
  localparam logic [FreqW-1:0]  SweepDeltaRst = 16'hFF6A; // -150
  localparam logic [CountW-1:0] HalfPeriodRst = 8'd10;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_BURST = 2'd1,
    KIND_CONST = 2'd2,
    KIND_SWEEP = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BEEP_TONE   = 3'd0,
    CFG_SWEEP_LOW   = 3'd1,
    CFG_SWEEP_HIGH  = 3'd2,
    CFG_SWEEP_DELTA = 3'd3,
    CFG_HALF_PERIOD = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_OFF   = 3'b001,
    MODE_BEEP  = 3'b010,
    MODE_SWEEP = 3'b100
  } mode_e;

  typedef struct packed {
    logic [FreqW-1:0]        beep_tone;
    logic [FreqW-1:0]        sweep_low;
    logic [FreqW-1:0]        sweep_high;
    logic signed [FreqW-1:0] sweep_delta;
    logic [CountW-1:0]       default_half_period;
  } bts_cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [1:0]        prio;
    logic [CountW-1:0] beep_count;
    logic [CountW-1:0] half_period_ticks;
  } bts_item_t;

  typedef struct packed {
    logic [FreqW-1:0] tone_freq;
    logic             sounding;
  } bts_result_t;

  // Half period of zero behaves as one.
  function automatic logic [CountW-1:0] nonzero_len(input logic [CountW-1:0] v);
    return (v == '0) ? CountW'(1) : v;
  endfunction

endpackage

### hdl/bts_cfg_regs.sv
// Configuration register bank of the buzzer tone sequencer.
`timescale 1ns / 1ps
module bts_cfg_regs
  import bts_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [FreqW-1:0]   cfg_data_i,
  output bts_cfg_t           cfg_o
);

  bts_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BEEP_TONE:   cfg_d.beep_tone = cfg_data_i;
        CFG_SWEEP_LOW:   cfg_d.sweep_low = cfg_data_i;
        CFG_SWEEP_HIGH:  cfg_d.sweep_high = cfg_data_i;
        CFG_SWEEP_DELTA: cfg_d.sweep_delta = cfg_data_i;
        CFG_HALF_PERIOD: cfg_d.default_half_period = cfg_data_i[CountW-1:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beep_tone           <= BeepToneRst;
      cfg_q.sweep_low           <= SweepLowRst;
      cfg_q.sweep_high          <= SweepHighRst;
      cfg_q.sweep_delta         <= SweepDeltaRst;
      cfg_q.default_half_period <= HalfPeriodRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/bts_core.sv
// Sound state and per-item update of the buzzer tone sequencer.
`timescale 1ns / 1ps
`include "buzzer_tone_sequencer_top_macros.svh"
module bts_core
  import bts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  bts_item_t   item_i,
  input  bts_cfg_t    cfg_i,
  output bts_result_t result_o
);

  logic              active_q, active_d;
  logic [1:0]        prio_q, prio_d;
  mode_e             mode_q, mode_d;
  logic [FreqW-1:0]  freq_q, freq_d;
  logic [CountW-1:0] beeps_q, beeps_d;
  logic [CountW-1:0] half_q, half_d;
  logic [CountW-1:0] pos_q, pos_d;

  // beep step
  logic [FreqW-1:0]  beep_freq;
  logic [CountW-1:0] beep_left;
  logic [CountW-1:0] beep_h;
  logic [CountW:0]   pos_inc;
  logic [CountW-1:0] beep_pos;

  // sweep step
  logic signed [FreqW+1:0] sweep_sum;
  logic                    sweep_wrap;
  logic                    delta_pos;
  logic [FreqW-1:0]        sweep_freq;

  logic take_start;

  always_comb begin
    beep_freq = freq_q;
    beep_left = beeps_q;
    if (pos_q == '0) begin
      if (freq_q == '0) begin
        beep_freq = cfg_i.beep_tone;
      end else begin
        beep_freq = '0;
        if (beeps_q != BeepsEndless) beep_left = beeps_q - CountW'(1);
      end
    end
    beep_h   = nonzero_len(half_q);
    pos_inc  = {1'b0, pos_q} + (CountW+1)'(1);
    beep_pos = (pos_inc >= {1'b0, beep_h}) ? '0 : pos_inc[CountW-1:0];
  end

  always_comb begin
    sweep_sum  = $signed({2'b00, freq_q}) +
                 $signed({{2{cfg_i.sweep_delta[FreqW-1]}}, cfg_i.sweep_delta});
    sweep_wrap = (sweep_sum <= $signed({2'b00, cfg_i.sweep_low})) ||
                 (sweep_sum >  $signed({2'b00, cfg_i.sweep_high}));
    delta_pos  = !cfg_i.sweep_delta[FreqW-1] && (cfg_i.sweep_delta != '0);
    sweep_freq = sweep_wrap ? (delta_pos ? cfg_i.sweep_low : cfg_i.sweep_high)
                            : sweep_sum[FreqW-1:0];
  end

  assign take_start = !active_q || !(prio_q > item_i.prio);

  always_comb begin
    active_d = active_q;
    prio_d   = prio_q;
    mode_d   = mode_q;
    freq_d   = freq_q;
    beeps_d  = beeps_q;
    half_d   = half_q;
    pos_d    = pos_q;
    result_o.tone_freq = '0;
    if (step_i) begin
      if (item_i.kind != KIND_TICK) begin
        if (take_start) begin
          active_d = 1'b1;
          prio_d   = item_i.prio;
          mode_d   = (item_i.kind == KIND_SWEEP) ? MODE_SWEEP : MODE_BEEP;
          freq_d   = '0;
          pos_d    = '0;
          unique case (item_i.kind)
            KIND_BURST: begin
              beeps_d = item_i.beep_count;
              half_d  = nonzero_len(cfg_i.default_half_period);
            end
            KIND_CONST: begin
              beeps_d = BeepsEndless;
              half_d  = nonzero_len(item_i.half_period_ticks);
            end
            default: begin
              beeps_d = '0;
              half_d  = nonzero_len(cfg_i.default_half_period);
            end
          endcase
        end
      end else if (active_q) begin
        unique case (mode_q)
          MODE_BEEP: begin
            if (beeps_q == '0) begin
              active_d = 1'b0;
            end else begin
              freq_d  = beep_freq;
              beeps_d = beep_left;
              pos_d   = beep_pos;
              result_o.tone_freq = beep_freq;
            end
          end
          MODE_SWEEP: begin
            freq_d = sweep_freq;
            result_o.tone_freq = sweep_freq;
          end
          default: ;
        endcase
      end
    end
    result_o.sounding = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      prio_q   <= '0;
      mode_q   <= MODE_OFF;
      freq_q   <= '0;
      beeps_q  <= '0;
      half_q   <= HalfPeriodRst;
      pos_q    <= '0;
    end else begin
      active_q <= active_d;
      prio_q   <= prio_d;
      mode_q   <= mode_d;
      freq_q   <= freq_d;
      beeps_q  <= beeps_d;
      half_q   <= half_d;
      pos_q    <= pos_d;
    end
  end

  `BTS_ASSERT_IMP(a_active_has_mode, clk_i, rst_ni, active_q, mode_q != MODE_OFF,
                  "active sound without a mode")
  `BTS_ASSERT_IMP(a_half_nonzero, clk_i, rst_ni, 1'b1, half_q != '0,
                  "stored half period is zero")
  `BTS_ASSERT_IMP(a_pos_in_period, clk_i, rst_ni, 1'b1, pos_q < half_q,
                  "period position beyond half period")

endmodule

### hdl/buzzer_tone_sequencer_top.sv
// Top level of the buzzer tone sequencer: input stage, core, result stage.
//
//  port group   dir   transfer condition             payload
//  in_*         in    in_valid_i  & in_ready_o       kind, prio, beep_count, half_period_ticks
//  out_*        out   out_valid_o & out_ready_i      tone_freq, sounding
//  cfg_*        in    cfg_we_i                       cfg_index_i, cfg_data_i
//
// One item per clock unless a tick waits on a stalled output: an item is held in
// the input register, the core updates the sound state, and a tick's result
// lands in the output register; starts give no result. A stalled output holds
// only ticks back; the input register keeps taking items while the result stage
// can drain. Reset clears all sound state at once.
`timescale 1ns / 1ps
`include "buzzer_tone_sequencer_top_macros.svh"
module buzzer_tone_sequencer_top
  import bts_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [1:0]         prio_i,
  input  logic [CountW-1:0]  beep_count_i,
  input  logic [CountW-1:0]  half_period_ticks_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [FreqW-1:0]   tone_freq_o,
  output logic               sounding_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [FreqW-1:0]   cfg_data_i
);

  bts_cfg_t    cfg;
  bts_item_t   item_q;
  logic        in_valid_q;
  logic        out_valid_q;
  bts_result_t res_q;
  bts_result_t core_res;
  logic        is_tick;
  logic        advance;
  logic        out_load;

  bts_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign is_tick  = (item_q.kind == KIND_TICK);
  // starts never need the result stage
  assign advance  = in_valid_q && (!is_tick || !out_valid_q || out_ready_i);
  assign out_load = advance && is_tick;
  assign in_ready_o = !in_valid_q || advance;

  bts_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      out_valid_q <= (out_valid_q && !out_ready_i) || out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.kind              <= kind_e'(kind_i);
      item_q.prio              <= prio_i;
      item_q.beep_count        <= beep_count_i;
      item_q.half_period_ticks <= half_period_ticks_i;
    end
    if (out_load) res_q <= core_res;
  end

  assign out_valid_o = out_valid_q;
  assign tone_freq_o = res_q.tone_freq;
  assign sounding_o  = res_q.sounding;

  `BTS_ASSERT_NXT(a_start_no_result, clk_i, rst_ni,
                  advance && !is_tick && !(out_valid_q && !out_ready_i), !out_valid_q,
                  "start command produced a result")
  `BTS_ASSERT_NXT(a_tick_gives_result, clk_i, rst_ni, out_load, out_valid_q,
                  "tick did not produce a result")
  `BTS_ASSERT_NXT(a_blocked_item_held, clk_i, rst_ni, in_valid_q && !advance, in_valid_q,
                  "blocked item dropped from input stage")

endmodule
